>>> rtl/core/gtbl_pkg.sv
// Package for the generational handle table: field widths, command, status,
// register index and sequencer state types, and the type range check.
// No dependencies.
package gtbl_pkg;

    localparam int TYPE_W   = 8;
    localparam int GEN_W    = 32;
    localparam int REF_W    = 16;
    localparam int RES_W    = 64;
    localparam int CNT_W    = 8;
    localparam int HANDLE_W = 64;
    localparam int CFG_W    = 8;

    localparam logic [REF_W-1:0] REF_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        CMD_INSTALL   = 3'd0,
        CMD_RESOLVE   = 3'd1,
        CMD_DUPLICATE = 3'd2,
        CMD_CLOSE     = 3'd3,
        CMD_CLOSE_ALL = 3'd4,
        CMD_INIT      = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOINIT    = 3'd1,
        ST_BADTYPE   = 3'd2,
        ST_FULL      = 3'd3,
        ST_STALE     = 3'd4,
        ST_WRONGTYPE = 3'd5,
        ST_CLOSEFAIL = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CFG_TABLE_LIMIT = 2'd0,
        CFG_MIN_TYPE    = 2'd1,
        CFG_MAX_TYPE    = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_INST_WR,
        S_SLOT,
        S_OBJ,
        S_DUP_WR,
        S_SCAN,
        S_DONE
    } state_t;

    function automatic logic type_ok(input logic [TYPE_W-1:0] t,
                                     input logic [TYPE_W-1:0] lo,
                                     input logic [TYPE_W-1:0] hi);
        return (t >= lo) && (t <= hi);
    endfunction

endpackage

>>> rtl/core/gtbl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gtbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/generational_handle_table.sv
// Generational handle table: top level with the command sequencer and counters.
// Depends on gtbl_pkg and gtbl_ram (slot memory and object memory).
//
// One command enters on the input channel (in_valid/in_ready) and gives exactly
// one result transaction on the output channel (out_valid/out_ready).
// Commands are handled one at a time; in_ready is high only while the
// sequencer is idle, and a new command may be taken while the previous result
// still waits in the output register.
// Close all walks the slot memory in index order up to the limit and goes on to
// the object memory only for active slots.
// A resolve, duplicate or close reads the slot memory, then the object memory;
// each write-back happens in the same cycle as the read data that it uses.
// Reset clears the valid bits, the counters and the ready flag at once; until an
// initialize command succeeds, install and close all answer "not initialised"
// and resolve, duplicate and close answer "stale".
// When the receiver stalls, the result holds in the output register and the
// sequencer waits in its final state; no result is lost.
// The user must write registers through the configuration port only while the
// block is idle; the block itself does not enforce this.
module generational_handle_table
    import gtbl_pkg::*;
#(
    parameter int MAX_SLOTS = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            command,
    input  logic [HANDLE_W-1:0]   handle_in,
    input  logic [TYPE_W-1:0]     new_type,
    input  logic [TYPE_W-1:0]     required_type,
    input  logic [RES_W-1:0]      resource_in,
    input  logic                  release_refused,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            status,
    output logic [HANDLE_W-1:0]   handle_out,
    output logic [RES_W-1:0]      resource_out,
    output logic                  final_release,
    output logic [CNT_W-1:0]      handle_count,
    output logic [CNT_W-1:0]      object_count,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int IW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOT_W = GEN_W + TYPE_W + IW;
    localparam int OBJ_W  = REF_W + TYPE_W + RES_W;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     limit_cfg_reg, min_reg, max_reg;
    logic                 ready_reg, ready_next;
    logic [CNT_W-1:0]     cur_limit_reg, cur_limit_next;
    logic [MAX_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [MAX_SLOTS-1:0] obj_valid_reg, obj_valid_next;
    logic [MAX_SLOTS-1:0] gen_wr_reg, gen_wr_next;
    logic [CNT_W-1:0]     live_h_reg, live_h_next, live_o_reg, live_o_next;
    logic [IW:0]          scan_reg, scan_next;
    logic                 fail_reg, fail_next;
    logic                 out_valid_reg, out_load;

    cmd_t                 cmd_reg, cmd_next;
    logic [HANDLE_W-1:0]  h_reg, h_next;
    logic [TYPE_W-1:0]    nt_reg, nt_next, et_reg, et_next;
    logic [RES_W-1:0]     rin_reg, rin_next;
    logic                 refused_reg, refused_next;
    logic [IW-1:0]        sidx_reg, sidx_next;
    logic [IW-1:0]        free_slot_reg, free_slot_next, free_obj_reg, free_obj_next;
    logic                 sf_reg, sf_next;
    logic [IW-1:0]        rd_addr_reg;
    logic [GEN_W-1:0]     sl_gen_reg, sl_gen_next;
    logic [TYPE_W-1:0]    sl_type_reg, sl_type_next;
    logic [IW-1:0]        sl_obj_reg, sl_obj_next;
    status_t              st_reg, st_next;
    logic [HANDLE_W-1:0]  hout_reg, hout_next;
    logic [RES_W-1:0]     rout_reg, rout_next;
    logic                 fin_reg, fin_next;
    status_t              o_status_reg;
    logic [HANDLE_W-1:0]  o_handle_reg;
    logic [RES_W-1:0]     o_res_reg;
    logic                 o_fin_reg;
    logic [CNT_W-1:0]     o_hc_reg, o_oc_reg;

    logic                 s_we, o_we;
    logic [IW-1:0]        s_waddr, s_raddr, o_waddr, o_raddr;
    logic [SLOT_W-1:0]    s_wdata, s_rdata;
    logic [OBJ_W-1:0]     o_wdata, o_rdata;

    logic [15:0]          enc;
    logic [TYPE_W-1:0]    ht;
    logic [GEN_W-1:0]     hgen;
    logic [IW-1:0]        h_idx;
    logic                 pre_ok;
    logic [IW-1:0]        free_slot_c, free_obj_c;
    logic                 sf_c, of_c;
    logic                 sv, is_ca, slot_ok, wrong_type, dup_full, slot_go;
    logic [TYPE_W-1:0]    s_type;
    logic [IW-1:0]        s_obj;
    logic [GEN_W-1:0]     rd_gen, gen_inc;
    logic                 ov, res_ok, dup_ok, cl_ok, cl_last;
    logic [REF_W-1:0]     o_refs;
    logic [TYPE_W-1:0]    o_type;
    logic [RES_W-1:0]     o_res;
    logic                 init_ok, inst_ok, scan_end, scan_hit;
    logic                 out_free;

    gtbl_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    gtbl_ram #(.WIDTH(OBJ_W), .DEPTH(MAX_SLOTS)) u_obj_ram (
        .clk   (clk),
        .we    (o_we),
        .waddr (o_waddr),
        .wdata (o_wdata),
        .raddr (o_raddr),
        .rdata (o_rdata)
    );

    assign enc   = h_reg[15:0];
    assign ht    = h_reg[23:16];
    assign hgen  = h_reg[63:32];
    assign h_idx = IW'(32'(enc) - 32'd1);
    assign pre_ok = ready_reg && (enc != 16'd0) && (32'(enc) <= 32'(cur_limit_reg))
                    && (32'(enc) <= MAX_SLOTS) && (h_reg[31:24] == 8'd0)
                    && (hgen != '0) && type_ok(ht, min_reg, max_reg);

    always_comb
    begin
        free_slot_c = '0;
        free_obj_c  = '0;
        sf_c        = 1'b0;
        of_c        = 1'b0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (i < int'(cur_limit_reg))
            begin
                if (!slot_valid_reg[i])
                begin
                    free_slot_c = IW'(i);
                    sf_c        = 1'b1;
                end
                if (!obj_valid_reg[i])
                begin
                    free_obj_c = IW'(i);
                    of_c       = 1'b1;
                end
            end
        end
    end

    assign sv         = slot_valid_reg[sidx_reg];
    assign s_obj      = s_rdata[IW-1:0];
    assign s_type     = s_rdata[IW +: TYPE_W];
    assign rd_gen     = gen_wr_reg[rd_addr_reg] ? s_rdata[IW+TYPE_W +: GEN_W] : GEN_W'(1);
    assign is_ca      = (cmd_reg == CMD_CLOSE_ALL);
    assign slot_ok    = is_ca ? (sv && type_ok(s_type, min_reg, max_reg))
                              : (pre_ok && sv && (rd_gen == hgen) && (s_type == ht));
    assign wrong_type = (cmd_reg == CMD_RESOLVE) && (et_reg != '0) && (s_type != et_reg);
    assign dup_full   = (cmd_reg == CMD_DUPLICATE) && (!sf_reg || (live_h_reg >= cur_limit_reg));
    assign slot_go    = slot_ok && !wrong_type && !dup_full;

    assign o_res   = o_rdata[RES_W-1:0];
    assign o_type  = o_rdata[RES_W +: TYPE_W];
    assign o_refs  = o_rdata[RES_W+TYPE_W +: REF_W];
    assign ov      = obj_valid_reg[sl_obj_reg];
    assign res_ok  = (32'(sl_obj_reg) < 32'(cur_limit_reg)) && ov && (o_refs != '0)
                     && (o_type == sl_type_reg);
    assign dup_ok  = ov && (o_refs != REF_MAX);
    assign cl_last = (o_refs == REF_W'(1));
    assign cl_ok   = ov && (o_refs != '0) && !(cl_last && refused_reg);
    assign gen_inc = ((sl_gen_reg + GEN_W'(1)) == '0) ? GEN_W'(1) : (sl_gen_reg + GEN_W'(1));

    assign init_ok  = (limit_cfg_reg != '0) && (32'(limit_cfg_reg) <= MAX_SLOTS);
    assign inst_ok  = ready_reg && type_ok(nt_reg, min_reg, max_reg) && sf_c && of_c;
    assign scan_end = (32'(scan_reg) >= 32'(cur_limit_reg));
    assign scan_hit = slot_valid_reg[scan_reg[IW-1:0]];
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                case (cmd_reg)
                    CMD_INSTALL:   state_next = inst_ok ? S_INST_WR : S_DONE;
                    CMD_RESOLVE,
                    CMD_DUPLICATE,
                    CMD_CLOSE:     state_next = S_SLOT;
                    CMD_CLOSE_ALL: state_next = ready_reg ? S_SCAN : S_DONE;
                    default:       state_next = S_DONE;
                endcase
            end
            S_INST_WR: state_next = S_DONE;
            S_SLOT:
            begin
                if (is_ca)
                begin
                    state_next = slot_ok ? S_OBJ : S_SCAN;
                end
                else
                begin
                    state_next = slot_go ? S_OBJ : S_DONE;
                end
            end
            S_OBJ:
            begin
                if (is_ca)
                begin
                    state_next = S_SCAN;
                end
                else if (cmd_reg == CMD_DUPLICATE && dup_ok)
                begin
                    state_next = S_DUP_WR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DUP_WR: state_next = S_DONE;
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_DONE;
                end
                else if (scan_hit)
                begin
                    state_next = S_SLOT;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ready_next      = ready_reg;
        cur_limit_next  = cur_limit_reg;
        slot_valid_next = slot_valid_reg;
        obj_valid_next  = obj_valid_reg;
        gen_wr_next     = gen_wr_reg;
        live_h_next     = live_h_reg;
        live_o_next     = live_o_reg;
        scan_next       = scan_reg;
        fail_next       = fail_reg;
        cmd_next        = cmd_reg;
        h_next          = h_reg;
        nt_next         = nt_reg;
        et_next         = et_reg;
        rin_next        = rin_reg;
        refused_next    = refused_reg;
        sidx_next       = sidx_reg;
        free_slot_next  = free_slot_reg;
        free_obj_next   = free_obj_reg;
        sf_next         = sf_reg;
        sl_gen_next     = sl_gen_reg;
        sl_type_next    = sl_type_reg;
        sl_obj_next     = sl_obj_reg;
        st_next         = st_reg;
        hout_next       = hout_reg;
        rout_next       = rout_reg;
        fin_next        = fin_reg;
        out_load        = 1'b0;
        s_we            = 1'b0;
        s_waddr         = sidx_reg;
        s_wdata         = '0;
        s_raddr         = sidx_reg;
        o_we            = 1'b0;
        o_waddr         = sl_obj_reg;
        o_wdata         = '0;
        o_raddr         = sl_obj_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = cmd_t'(command);
                    h_next       = handle_in;
                    nt_next      = new_type;
                    et_next      = required_type;
                    rin_next     = resource_in;
                    refused_next = release_refused;
                    st_next      = ST_OK;
                    hout_next    = '0;
                    rout_next    = '0;
                    fin_next     = 1'b0;
                end
            end
            S_LOOKUP:
            begin
                free_slot_next = free_slot_c;
                free_obj_next  = free_obj_c;
                sf_next        = sf_c;
                case (cmd_reg)
                    CMD_INSTALL:
                    begin
                        s_raddr = free_slot_c;
                        if (!ready_reg)
                        begin
                            st_next = ST_NOINIT;
                        end
                        else if (!type_ok(nt_reg, min_reg, max_reg))
                        begin
                            st_next = ST_BADTYPE;
                        end
                        else if (!sf_c || !of_c)
                        begin
                            st_next = ST_FULL;
                        end
                    end
                    CMD_RESOLVE,
                    CMD_DUPLICATE,
                    CMD_CLOSE:
                    begin
                        s_raddr   = h_idx;
                        sidx_next = h_idx;
                    end
                    CMD_CLOSE_ALL:
                    begin
                        scan_next = '0;
                        fail_next = 1'b0;
                        if (!ready_reg)
                        begin
                            st_next = ST_NOINIT;
                        end
                    end
                    CMD_INIT:
                    begin
                        if (!init_ok)
                        begin
                            st_next = ST_NOINIT;
                        end
                        else
                        begin
                            ready_next      = 1'b1;
                            cur_limit_next  = limit_cfg_reg;
                            slot_valid_next = '0;
                            obj_valid_next  = '0;
                            gen_wr_next     = '0;
                            live_h_next     = '0;
                            live_o_next     = '0;
                        end
                    end
                    default:
                    begin
                        st_next = ST_OK;
                    end
                endcase
            end
            S_INST_WR:
            begin
                s_we    = 1'b1;
                s_waddr = free_slot_reg;
                s_wdata = {rd_gen, nt_reg, free_obj_reg};
                o_we    = 1'b1;
                o_waddr = free_obj_reg;
                o_wdata = {REF_W'(1), nt_reg, rin_reg};
                slot_valid_next[free_slot_reg] = 1'b1;
                gen_wr_next[free_slot_reg]     = 1'b1;
                obj_valid_next[free_obj_reg]   = 1'b1;
                live_h_next = live_h_reg + CNT_W'(1);
                live_o_next = live_o_reg + CNT_W'(1);
                hout_next   = {rd_gen, 8'd0, nt_reg, 16'(32'(free_slot_reg) + 32'd1)};
            end
            S_SLOT:
            begin
                o_raddr      = s_obj;
                sl_gen_next  = rd_gen;
                sl_type_next = s_type;
                sl_obj_next  = s_obj;
                if (is_ca)
                begin
                    if (!slot_ok)
                    begin
                        fail_next = 1'b1;
                        scan_next = scan_reg + (IW + 1)'(1);
                    end
                end
                else if (!slot_ok)
                begin
                    st_next = ST_STALE;
                end
                else if (wrong_type)
                begin
                    st_next = ST_WRONGTYPE;
                end
                else if (dup_full)
                begin
                    st_next = ST_FULL;
                end
            end
            S_OBJ:
            begin
                case (cmd_reg)
                    CMD_RESOLVE:
                    begin
                        if (res_ok)
                        begin
                            rout_next = o_res;
                        end
                        else
                        begin
                            st_next = ST_STALE;
                        end
                    end
                    CMD_DUPLICATE:
                    begin
                        s_raddr = free_slot_reg;
                        if (dup_ok)
                        begin
                            o_we    = 1'b1;
                            o_wdata = {o_refs + REF_W'(1), o_type, o_res};
                        end
                        else
                        begin
                            st_next = ST_STALE;
                        end
                    end
                    default:
                    begin
                        if (is_ca)
                        begin
                            scan_next = scan_reg + (IW + 1)'(1);
                            if (!cl_ok)
                            begin
                                fail_next = 1'b1;
                            end
                        end
                        else if (!ov || o_refs == '0)
                        begin
                            st_next = ST_STALE;
                        end
                        else if (!cl_ok)
                        begin
                            st_next = ST_CLOSEFAIL;
                        end
                        if (cl_ok)
                        begin
                            s_we    = 1'b1;
                            s_wdata = {gen_inc, {TYPE_W{1'b0}}, {IW{1'b0}}};
                            o_we    = 1'b1;
                            o_wdata = {o_refs - REF_W'(1), o_type, o_res};
                            slot_valid_next[sidx_reg] = 1'b0;
                            gen_wr_next[sidx_reg]     = 1'b1;
                            live_h_next = live_h_reg - CNT_W'(1);
                            if (cl_last)
                            begin
                                obj_valid_next[sl_obj_reg] = 1'b0;
                                live_o_next = live_o_reg - CNT_W'(1);
                                if (!is_ca)
                                begin
                                    rout_next = o_res;
                                    fin_next  = 1'b1;
                                end
                            end
                        end
                    end
                endcase
            end
            S_DUP_WR:
            begin
                s_we    = 1'b1;
                s_waddr = free_slot_reg;
                s_wdata = {rd_gen, sl_type_reg, sl_obj_reg};
                slot_valid_next[free_slot_reg] = 1'b1;
                gen_wr_next[free_slot_reg]     = 1'b1;
                live_h_next = live_h_reg + CNT_W'(1);
                hout_next   = {rd_gen, 8'd0, sl_type_reg, 16'(32'(free_slot_reg) + 32'd1)};
            end
            S_SCAN:
            begin
                s_raddr   = scan_reg[IW-1:0];
                sidx_next = scan_reg[IW-1:0];
                if (scan_end)
                begin
                    st_next = fail_reg ? ST_CLOSEFAIL : ST_OK;
                end
                else if (!scan_hit)
                begin
                    scan_next = scan_reg + (IW + 1)'(1);
                end
            end
            S_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            limit_cfg_reg  <= CFG_W'(128);
            min_reg        <= CFG_W'(1);
            max_reg        <= CFG_W'(8);
            ready_reg      <= 1'b0;
            cur_limit_reg  <= '0;
            slot_valid_reg <= '0;
            obj_valid_reg  <= '0;
            gen_wr_reg     <= '0;
            live_h_reg     <= '0;
            live_o_reg     <= '0;
            scan_reg       <= '0;
            fail_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ready_reg      <= ready_next;
            cur_limit_reg  <= cur_limit_next;
            slot_valid_reg <= slot_valid_next;
            obj_valid_reg  <= obj_valid_next;
            gen_wr_reg     <= gen_wr_next;
            live_h_reg     <= live_h_next;
            live_o_reg     <= live_o_next;
            scan_reg       <= scan_next;
            fail_reg       <= fail_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_TABLE_LIMIT: limit_cfg_reg <= cfg_data;
                    CFG_MIN_TYPE:    min_reg       <= cfg_data;
                    CFG_MAX_TYPE:    max_reg       <= cfg_data;
                    default:         limit_cfg_reg <= limit_cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        h_reg         <= h_next;
        nt_reg        <= nt_next;
        et_reg        <= et_next;
        rin_reg       <= rin_next;
        refused_reg   <= refused_next;
        sidx_reg      <= sidx_next;
        free_slot_reg <= free_slot_next;
        free_obj_reg  <= free_obj_next;
        sf_reg        <= sf_next;
        rd_addr_reg   <= s_raddr;
        sl_gen_reg    <= sl_gen_next;
        sl_type_reg   <= sl_type_next;
        sl_obj_reg    <= sl_obj_next;
        st_reg        <= st_next;
        hout_reg      <= hout_next;
        rout_reg      <= rout_next;
        fin_reg       <= fin_next;
        if (out_load)
        begin
            o_status_reg <= st_reg;
            o_handle_reg <= hout_reg;
            o_res_reg    <= rout_reg;
            o_fin_reg    <= fin_reg;
            o_hc_reg     <= live_h_reg;
            o_oc_reg     <= live_o_reg;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = o_status_reg;
    assign handle_out    = o_handle_reg;
    assign resource_out  = o_res_reg;
    assign final_release = o_fin_reg;
    assign handle_count  = o_hc_reg;
    assign object_count  = o_oc_reg;

endmodule

>>> rtl/core/gtbl_checker.sv
// Port-level checker for the generational handle table, bound to the top level.
// Depends on gtbl_pkg and generational_handle_table.
module gtbl_checker
    import gtbl_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [2:0]          status,
    input logic [HANDLE_W-1:0] handle_out,
    input logic                final_release,
    input logic [CNT_W-1:0]    handle_count,
    input logic [CNT_W-1:0]    object_count
);

    // A stalled result transaction holds its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(handle_out))
        else $error("result changed while stalled");

    // Every new handle has zero reserved bits, a nonzero generation and index.
    a_handle_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && handle_out != '0 |-> handle_out[31:24] == 8'd0
            && handle_out[63:32] != 32'd0 && handle_out[15:0] != 16'd0
            && status == ST_OK)
        else $error("malformed handle");

    // A final release only comes from a successful close, which has no handle.
    a_final_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_release |-> status == ST_OK && handle_out == '0)
        else $error("final release with bad status");

    // Each live object is referenced by at least one live handle.
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> object_count <= handle_count)
        else $error("more objects than handles");

endmodule

bind generational_handle_table gtbl_checker u_gtbl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .handle_out    (handle_out),
    .final_release (final_release),
    .handle_count  (handle_count),
    .object_count  (object_count)
);
